// ===== rtl/lru_page_replacement_top_macros.svh =====
// assertion macros for the lru page replacement block
// used by lru_page_replacement_top; expects clk and rst_n in scope
`ifndef LRU_PAGE_REPLACEMENT_TOP_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_TOP_MACROS_SVH

// condition must hold at every edge outside reset
`define LRU_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// when ante holds, cons must hold (non-overlapping implication, |=>)
`define LRU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lru_pkg.sv =====
// shared types and constants for the lru page replacement block
// no dependencies
package lru_pkg;

  localparam int FRAMES      = 4;
  localparam int PAGE_BITS   = 16;
  localparam int RANK_W      = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int IN_PAGE_W   = 16;
  localparam int OUT_PAGE_W  = 16;
  localparam int OUT_IDX_W   = 2;
  localparam int FAULT_W     = 32;

  typedef enum logic [0:0] {
    ST_IDLE   = 1'b0,
    ST_UPDATE = 1'b1
  } state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;    // capture the incoming page reference
    logic commit;  // update frames and load the result register
  } dp_cmd_t;

endpackage

// ===== rtl/lru_ctrl.sv =====
// controller state machine for the lru page replacement block
// depends on lru_pkg
module lru_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output lru_pkg::dp_cmd_t cmd
);

  lru_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lru_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    cmd.load      = 1'b0;
    cmd.commit    = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      lru_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = lru_pkg::ST_UPDATE;
        end
      end
      lru_pkg::ST_UPDATE: begin
        // result register free or draining this cycle
        if (!out_valid_r || out_ready) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = lru_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lru_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/lru_dpath.sv =====
// frame table, lookup, victim choice and result register
// depends on lru_pkg
module lru_dpath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  lru_pkg::dp_cmd_t                    cmd,
  input  logic [lru_pkg::IN_PAGE_W-1:0]       in_page_number,
  output logic                                out_hit,
  output logic [lru_pkg::OUT_IDX_W-1:0]       out_frame_index,
  output logic                                out_evicted_valid,
  output logic [lru_pkg::OUT_PAGE_W-1:0]      out_evicted_page,
  output logic [lru_pkg::FAULT_W-1:0]         out_fault_total
);

  localparam int FR = lru_pkg::FRAMES;
  localparam int PB = lru_pkg::PAGE_BITS;
  localparam int RW = lru_pkg::RANK_W;
  localparam int FW = lru_pkg::FAULT_W;

  logic [PB-1:0] page_r;
  logic [PB-1:0] frame_page_r [FR];
  logic [FR-1:0] frame_valid_r;
  logic [RW-1:0] rank_r       [FR];
  logic [RW-1:0] rank_nxt     [FR];
  logic [FW-1:0] fault_r, fault_nxt;

  logic          hit, found_empty, evict;
  logic [RW-1:0] hit_idx, empty_idx, lru_idx, victim, victim_rank;
  logic [PB-1:0] victim_page;
  logic [31:0]   in_wide, ev_wide, idx_wide;

  assign in_wide = 32'(in_page_number);

  always_comb begin
    hit         = 1'b0;
    hit_idx     = '0;
    found_empty = 1'b0;
    empty_idx   = '0;
    lru_idx     = '0;
    for (int i = 0; i < FR; i++) begin
      if (!hit && frame_valid_r[i] && frame_page_r[i] == page_r) begin
        hit     = 1'b1;
        hit_idx = RW'(i);
      end
      if (!found_empty && !frame_valid_r[i]) begin
        found_empty = 1'b1;
        empty_idx   = RW'(i);
      end
      if (rank_r[i] == RW'(FR - 1)) begin
        lru_idx = RW'(i);
      end
    end
    evict  = !hit && !found_empty;
    victim = hit ? hit_idx : (found_empty ? empty_idx : lru_idx);
  end

  assign victim_rank = rank_r[victim];
  assign victim_page = frame_page_r[victim];

  // promote victim to most recent, age everything more recent than it
  always_comb begin
    for (int i = 0; i < FR; i++) begin
      if (RW'(i) == victim) begin
        rank_nxt[i] = '0;
      end else if (rank_r[i] < victim_rank) begin
        rank_nxt[i] = rank_r[i] + RW'(1);
      end else begin
        rank_nxt[i] = rank_r[i];
      end
    end
  end

  assign fault_nxt = (!hit && fault_r != {FW{1'b1}}) ? fault_r + FW'(1) : fault_r;
  assign ev_wide   = evict ? 32'(victim_page) : 32'd0;
  assign idx_wide  = 32'(victim);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_valid_r <= '0;
      fault_r       <= '0;
      for (int i = 0; i < FR; i++) begin
        rank_r[i] <= RW'(i);
      end
    end else if (cmd.commit) begin
      frame_valid_r[victim] <= 1'b1;
      fault_r               <= fault_nxt;
      for (int i = 0; i < FR; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      page_r <= in_wide[PB-1:0];
    end
    if (cmd.commit) begin
      if (!hit) begin
        frame_page_r[victim] <= page_r;
      end
      out_hit           <= hit;
      out_frame_index   <= idx_wide[lru_pkg::OUT_IDX_W-1:0];
      out_evicted_valid <= evict;
      out_evicted_page  <= ev_wide[lru_pkg::OUT_PAGE_W-1:0];
      out_fault_total   <= fault_nxt;
    end
  end

endmodule

// ===== rtl/lru_page_replacement_top.sv =====
// lru page replacement unit: top level joining controller and datapath
// depends on lru_pkg, lru_ctrl, lru_dpath, lru_page_replacement_top_macros.svh
//
// usage
//   input channel: one page reference per transfer on in_page_number
//   result channel: one result per reference (hit, frame, eviction, fault count)
//   four fully associative frames with exact lru ranking
// sequencing
//   a reference is captured in the idle state; the update state then updates the
//   frame table and loads the result register once that register is free
//   the sequencer takes no new reference until the last one has committed
// reset
//   rst_n low clears all frames to empty, ranks to frame order, fault count
//   to zero and drops out_valid
// receiver stall
//   the result register holds while out_ready is low; one more reference is
//   captured meanwhile and waits in the update state until the register frees
`include "lru_page_replacement_top_macros.svh"

module lru_page_replacement_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [lru_pkg::IN_PAGE_W-1:0]     in_page_number,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_hit,
  output logic [lru_pkg::OUT_IDX_W-1:0]     out_frame_index,
  output logic                              out_evicted_valid,
  output logic [lru_pkg::OUT_PAGE_W-1:0]    out_evicted_page,
  output logic [lru_pkg::FAULT_W-1:0]       out_fault_total
);

  // command bundle from sequencer to datapath
  lru_pkg::dp_cmd_t cmd;

  lru_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  lru_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_page_number    (in_page_number),
    .out_hit           (out_hit),
    .out_frame_index   (out_frame_index),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_fault_total   (out_fault_total)
  );

  // a hit never evicts
  `LRU_ASSERT_ALWAYS(a_hit_no_evict, !(out_valid && out_hit && out_evicted_valid),
    "hit reported together with an eviction")

  // an eviction implies at least one fault has been counted
  `LRU_ASSERT_ALWAYS(a_evict_counted, !(out_valid && out_evicted_valid) || out_fault_total != '0,
    "eviction with zero fault count")

  // after a transfer in, the sequencer is busy and input ready drops
  `LRU_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready,
    "input ready again directly after a transfer")

  // fault count never goes backwards between results
  `LRU_ASSERT_NEXT(a_fault_mono, out_valid, out_fault_total >= $past(out_fault_total),
    "fault count decreased")

endmodule

// ===== sim/lru_result_checker.sv =====
`timescale 1ns / 1ps
// result checker for lru_page_replacement_top: keeps its own frame table and
// rank order, predicts one result per reference and compares result transfers
// depends on lru_pkg
module lru_result_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [lru_pkg::IN_PAGE_W-1:0]     in_page_number,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic                              out_hit,
  input  logic [lru_pkg::OUT_IDX_W-1:0]     out_frame_index,
  input  logic                              out_evicted_valid,
  input  logic [lru_pkg::OUT_PAGE_W-1:0]    out_evicted_page,
  input  logic [lru_pkg::FAULT_W-1:0]       out_fault_total,
  output int                                mismatch_count,
  output int                                outstanding
);

  localparam int REPORT_LIMIT = 10;
  localparam logic [lru_pkg::RANK_W-1:0] OLDEST_RANK =
    lru_pkg::RANK_W'(lru_pkg::FRAMES - 1);

  typedef struct packed {
    logic                           hit;
    logic [lru_pkg::OUT_IDX_W-1:0]  frame_index;
    logic                           evicted_valid;
    logic [lru_pkg::OUT_PAGE_W-1:0] evicted_page;
    logic [lru_pkg::FAULT_W-1:0]    fault_total;
  } lru_result_t;

  logic [lru_pkg::PAGE_BITS-1:0] frame_page [lru_pkg::FRAMES];
  logic                          frame_valid [lru_pkg::FRAMES];
  logic [lru_pkg::RANK_W-1:0]    frame_rank [lru_pkg::FRAMES];
  logic [lru_pkg::FAULT_W-1:0]   fault_count;

  lru_result_t expected_results [$];
  int          error_total;

  // one page reference: match, else fill lowest empty, else replace oldest
  function automatic lru_result_t lookup_page(input logic [lru_pkg::IN_PAGE_W-1:0] ref_page);
    logic [lru_pkg::PAGE_BITS-1:0] page;
    logic [31:0]                   slot;
    logic                          hit;
    logic                          found_empty;
    logic [lru_pkg::RANK_W-1:0]    old_rank;
    lru_result_t                   res;
    page = ref_page[lru_pkg::PAGE_BITS-1:0];
    res = '0;
    slot = 0;
    hit = 1'b0;
    found_empty = 1'b0;
    for (int i = 0; i < lru_pkg::FRAMES; i++)
      if (!hit && frame_valid[i] && frame_page[i] == page) begin
        hit = 1'b1;
        slot = i;
      end
    if (!hit) begin
      for (int i = 0; i < lru_pkg::FRAMES; i++)
        if (!found_empty && !frame_valid[i]) begin
          found_empty = 1'b1;
          slot = i;
        end
      if (!found_empty) begin
        for (int i = 0; i < lru_pkg::FRAMES; i++)
          if (frame_rank[i] == OLDEST_RANK) slot = i;
        res.evicted_valid = 1'b1;
        res.evicted_page = frame_page[slot];
      end
      frame_page[slot] = page;
      frame_valid[slot] = 1'b1;
      if (fault_count != '1) fault_count = fault_count + 1'b1;
    end
    old_rank = frame_rank[slot];
    for (int i = 0; i < lru_pkg::FRAMES; i++)
      if (frame_rank[i] < old_rank) frame_rank[i] = frame_rank[i] + 1'b1;
    frame_rank[slot] = '0;
    res.hit = hit;
    res.frame_index = slot[lru_pkg::OUT_IDX_W-1:0];
    res.fault_total = fault_count;
    return res;
  endfunction

  always @(posedge clk) begin
    lru_result_t got;
    lru_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < lru_pkg::FRAMES; i++) begin
        frame_page[i] = '0;
        frame_valid[i] = 1'b0;
        frame_rank[i] = lru_pkg::RANK_W'(i);
      end
      fault_count = '0;
      expected_results.delete();
      error_total = 0;
      mismatch_count <= 0;
      outstanding <= 0;
    end else begin
      // results first: a result can never belong to a reference taken this edge
      if (out_valid && out_ready) begin
        got = '{out_hit, out_frame_index, out_evicted_valid, out_evicted_page,
                out_fault_total};
        if (expected_results.size() == 0) begin
          error_total++;
          if (error_total <= REPORT_LIMIT)
            $display("%0t: result with none pending: ",
                     "hit=%0d frame=%0d evict=%0d/%h faults=%0d",
                     $realtime, got.hit, got.frame_index, got.evicted_valid,
                     got.evicted_page, got.fault_total);
        end else begin
          want = expected_results.pop_front();
          if (got.hit !== want.hit || got.frame_index !== want.frame_index ||
              got.evicted_valid !== want.evicted_valid ||
              got.evicted_page !== want.evicted_page ||
              got.fault_total !== want.fault_total) begin
            error_total++;
            if (error_total <= REPORT_LIMIT)
              $display("%0t: mismatch exp hit=%0d frame=%0d evict=%0d/%h faults=%0d, ",
                       "got hit=%0d frame=%0d evict=%0d/%h faults=%0d",
                       $realtime, want.hit, want.frame_index, want.evicted_valid,
                       want.evicted_page, want.fault_total, got.hit, got.frame_index,
                       got.evicted_valid, got.evicted_page, got.fault_total);
          end
        end
      end
      if (in_valid && in_ready) expected_results.push_back(lookup_page(in_page_number));
      mismatch_count <= error_total;
      outstanding <= expected_results.size();
    end
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// testbench top for lru_page_replacement_top: drives page references in bursts,
// stalls the result side and reports the verdict from lru_result_checker
// depends on lru_pkg, lru_result_checker, lru_page_replacement_top
module tb;

  localparam int RANDOM_REFS = 1035;
  // longest quiet stretch of a correct run is a sender gap plus a long stall
  localparam int IDLE_LIMIT  = 2000;
  localparam int SETTLE      = 8;

  // result-side stall modes
  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_MOSTLY,
    RDY_RARELY,
    RDY_BURSTY
  } ready_mode_t;

  // shapes of random reference sequences
  typedef enum logic [1:0] {
    SEQ_WORKING_SET,
    SEQ_SWEEP,
    SEQ_NOISE,
    SEQ_CORNER
  } ref_pattern_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic [lru_pkg::IN_PAGE_W-1:0]     in_page_number = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic                              out_hit;
  logic [lru_pkg::OUT_IDX_W-1:0]     out_frame_index;
  logic                              out_evicted_valid;
  logic [lru_pkg::OUT_PAGE_W-1:0]    out_evicted_page;
  logic [lru_pkg::FAULT_W-1:0]       out_fault_total;

  int          mismatch_count;
  int          outstanding;
  int          refs_sent;
  int          burst_left = 30;  // directed part goes out back to back
  int          quiet_cycles;
  int          phase_left;
  ready_mode_t ready_mode = RDY_ALWAYS;

  always #6 clk = ~clk;

  lru_page_replacement_top DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_page_number    (in_page_number),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_hit           (out_hit),
    .out_frame_index   (out_frame_index),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_fault_total   (out_fault_total)
  );

  lru_result_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_page_number    (in_page_number),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_hit           (out_hit),
    .out_frame_index   (out_frame_index),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_fault_total   (out_fault_total),
    .mismatch_count    (mismatch_count),
    .outstanding       (outstanding)
  );

  // result-side stalls: the mode is redrawn at random each time a phase runs out
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      phase_left <= 0;
    end else begin
      if (phase_left == 0) begin
        ready_mode <= ready_mode_t'($urandom_range(0, 3));
        phase_left <= $urandom_range(40, 300);
      end else begin
        phase_left <= phase_left - 1;
      end
      case (ready_mode)
        RDY_ALWAYS: out_ready <= 1'b1;
        RDY_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
        RDY_RARELY: out_ready <= ($urandom_range(0, 3) == 0);
        default:    out_ready <= ((phase_left % 16) < 4);  // ready only in short windows between long stalls
      endcase
    end
  end

  // watchdog: any transfer on either side restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // one reference transfer; opens a gap and a new burst when the burst runs out
  task automatic send_page(input logic [lru_pkg::IN_PAGE_W-1:0] page);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      if ($urandom_range(0, 9) == 0) burst_left = $urandom_range(100, 200);
      else burst_left = $urandom_range(1, 30);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_page_number <= page;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    refs_sent++;
  endtask

  // hold the sender off until every reference has its result
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    ref_pattern_t                  pattern;
    logic [lru_pkg::IN_PAGE_W-1:0] work_set [6];
    logic [lru_pkg::IN_PAGE_W-1:0] base;
    int                            set_size;
    int                            seq_len;
    int                            next_drain;
    int                            pick;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // page zero against empty frames that also hold zero: must miss into frame 0
    send_page(16'h0000);
    send_page(16'h0000);           // now a real hit
    send_page(16'hFFFF);           // fill the remaining empty frames in order
    send_page(16'h5555);
    send_page(16'hAAAA);
    send_page(16'h0000);           // hit on the least recent frame
    send_page(16'hFFFF);           // again the least recent one
    send_page(16'h1234);           // table full: replaces 0x5555
    send_page(16'h5555);           // replaces 0xAAAA
    send_page(16'h1234);           // hit one below the top
    send_page(16'h1234);           // hit on the most recent frame
    send_page(16'h8000);           // replaces page zero
    send_page(16'h0001);
    send_page(16'h7FFF);
    send_page(16'h0000);           // page zero comes back as a fault
    send_page(16'hFFFE);
    drain_results();

    next_drain = refs_sent + $urandom_range(150, 350);
    while (refs_sent < RANDOM_REFS + 16) begin
      pick = $urandom_range(0, 9);
      if (pick < 6)      pattern = SEQ_WORKING_SET;
      else if (pick < 7) pattern = SEQ_SWEEP;
      else if (pick < 9) pattern = SEQ_NOISE;
      else               pattern = SEQ_CORNER;
      base = 16'($urandom_range(0, 65535));
      case (pattern)
        SEQ_WORKING_SET: begin
          // a few pages revisited at random: hits, refills and evictions;
          // some pages differ from the base in a single bit
          set_size = $urandom_range(2, 6);
          for (int k = 0; k < 6; k++)
            work_set[k] = $urandom_range(0, 1) ? 16'($urandom_range(0, 65535))
                                               : base ^ (16'h1 << $urandom_range(0, 15));
          seq_len = $urandom_range(8, 40);
          repeat (seq_len) send_page(work_set[$urandom_range(0, set_size - 1)]);
        end
        SEQ_SWEEP: begin
          // one page more than the frames, in a loop: after the first pass every reference faults
          seq_len = $urandom_range(2, 4);
          repeat (seq_len)
            for (int k = 0; k <= lru_pkg::FRAMES; k++) send_page(16'(base + k));
        end
        SEQ_NOISE: begin
          seq_len = $urandom_range(1, 8);
          repeat (seq_len) send_page(16'($urandom_range(0, 65535)));
        end
        default: begin
          seq_len = $urandom_range(4, 12);
          repeat (seq_len)
            case ($urandom_range(0, 4))
              0:       send_page(16'h0000);
              1:       send_page(16'hFFFF);
              2:       send_page(16'h8000);
              3:       send_page(16'h7FFF);
              default: send_page(16'h0001);
            endcase
        end
      endcase
      if (refs_sent >= next_drain) begin
        drain_results();
        next_drain = refs_sent + $urandom_range(150, 350);
      end
    end

    drain_results();
    repeat (SETTLE) @(posedge clk);
    if (mismatch_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
